@@ src/stl_pkg.sv @@
// Shared types, token codes and character helpers for the script token lexer.
// Used by stl_scan, script_token_lexer_top and the sim benches; no other dependencies.
`default_nettype none

package stl_pkg;

   localparam longint unsigned MAX_SOURCE_BYTES_DEF = 64'd1048576;

   localparam int OFF_W  = 20;
   localparam int LEN_W  = 21;
   localparam int LINE_W = 16;
   localparam int KIND_W = 4;

   localparam logic [OFF_W-1:0]  OFF_MAX  = 20'hFFFFF;
   localparam logic [LEN_W-1:0]  LEN_MAX  = 21'h100000;
   localparam logic [LINE_W-1:0] LINE_MAX = 16'hFFFF;
   localparam logic [LINE_W-1:0] START_LINE_RESET = 16'd1;

   // results queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOTS       = 3;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_COLON   = 4'd0;
   localparam logic [KIND_W-1:0] KIND_LBRACE  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_LBRACE2 = 4'd2;
   localparam logic [KIND_W-1:0] KIND_RBRACE  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_RBRACE2 = 4'd4;
   localparam logic [KIND_W-1:0] KIND_ARROW   = 4'd5;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 4'd6;
   localparam logic [KIND_W-1:0] KIND_STRING  = 4'd7;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 4'd8;
   localparam logic [KIND_W-1:0] KIND_KEYWORD = 4'd9;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'd13;
   localparam logic [KIND_W-1:0] KIND_END     = 4'd14;

   // characters
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // keywords: Listen, Animate, Delegate, Vir
   localparam logic [7:0] KW_TEXT [4][8] = '{
      '{"L", "i", "s", "t", "e", "n", 8'h00, 8'h00},
      '{"A", "n", "i", "m", "a", "t", "e", 8'h00},
      '{"D", "e", "l", "e", "g", "a", "t", "e"},
      '{"V", "i", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [3:0] KW_LEN [4] = '{4'd6, 4'd7, 4'd8, 4'd3};

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      logic [LINE_W-1:0] line;
      logic              last;
   } token_type;

   // all tokens caused by one accepted transaction
   typedef struct packed {
      logic [1:0]            count;
      token_type [SLOTS-1:0] tok;
   } entry_type;

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic logic is_word_char(input logic [7:0] b);
      return is_alpha(b) || (b >= "0" && b <= "9") || b == CH_UNDER;
   endfunction

   function automatic logic [LINE_W-1:0] line_up(input logic [LINE_W-1:0] l);
      return (l != LINE_MAX) ? l + 16'd1 : l;
   endfunction

   function automatic logic [3:0] wlen_up(input logic [3:0] wl);
      return (wl != 4'hF) ? wl + 4'd1 : wl;
   endfunction

   // drop keywords that no longer match after byte b at position wl
   function automatic logic [3:0] kw_step(input logic [3:0] cand, input logic [3:0] wl,
                                          input logic [7:0] b);
      logic [3:0] res;
      res = cand;
      for (int k = 0; k < 4; k++) begin
         if (wl >= KW_LEN[k] || KW_TEXT[k][wl[2:0]] != b) begin
            res[k] = 1'b0;
         end
      end
      return res;
   endfunction

   function automatic logic [KIND_W-1:0] kw_kind(input logic [3:0] cand,
                                                 input logic [3:0] wl);
      logic [KIND_W-1:0] res;
      res = KIND_IDENT;
      for (int k = 3; k >= 0; k--) begin
         if (cand[k] && wl == KW_LEN[k]) begin
            res = KIND_KEYWORD + KIND_W'(k);
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ src/stl_scan.sv @@
// Scanner state and per-byte token decision for the script token lexer.
// Depends on stl_pkg; produces at most one queue entry of up to three tokens per transaction.
`default_nettype none

module stl_scan #(
   parameter longint unsigned MAX_SOURCE_BYTES = stl_pkg::MAX_SOURCE_BYTES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire logic [7:0]         data_byte,
   input  wire logic               byte_present,
   input  wire logic               end_of_source,
   input  wire logic               csr_write,
   input  wire logic [15:0]        csr_data,
   output logic                    push,
   output stl_pkg::entry_type      entry
);
   import stl_pkg::*;

   localparam int PosW = $clog2(MAX_SOURCE_BYTES + 1);
   localparam int ExtW = (PosW > LEN_W) ? PosW : LEN_W;
   localparam logic [PosW-1:0] PosMax = PosW'(MAX_SOURCE_BYTES);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_LBRACE = 3'd1;
   localparam logic [2:0] MODE_RBRACE = 3'd2;
   localparam logic [2:0] MODE_MINUS  = 3'd3;
   localparam logic [2:0] MODE_STRING = 3'd4;
   localparam logic [2:0] MODE_IDENT  = 3'd5;

   function automatic logic [OFF_W-1:0] sat_off(input logic [PosW-1:0] v);
      logic [ExtW-1:0] e;
      e = ExtW'(v);
      return (e > ExtW'(OFF_MAX)) ? OFF_MAX : e[OFF_W-1:0];
   endfunction

   function automatic logic [LEN_W-1:0] sat_len(input logic [PosW-1:0] v);
      logic [ExtW-1:0] e;
      e = ExtW'(v);
      return (e > ExtW'(LEN_MAX)) ? LEN_MAX : e[LEN_W-1:0];
   endfunction

   logic [2:0]        mode_ff, mode_in, mode_mid;
   logic              qs_ff, qs_in, qs_mid;
   logic [PosW-1:0]   begin_ff, begin_in, begin_mid;
   logic [PosW-1:0]   pos_ff, pos_in, pos_mid;
   logic [15:0]       line_ff, line_in, line_mid;
   logic [3:0]        cand_ff, cand_in, cand_mid;
   logic [3:0]        wlen_ff, wlen_in, wlen_mid;
   logic [15:0]       start_line_ff, start_line_in;

   logic [PosW-1:0]   here, after;
   logic [7:0]        partner;
   logic [KIND_W-1:0] kind_dbl, kind_single;
   logic              fall, a_long;
   logic [3:0]        tok_v;
   token_type         tok_c [4];
   logic [1:0]        slot;

   assign here  = pos_ff;
   assign after = (pos_ff != PosMax) ? pos_ff + PosW'(1) : pos_ff;

   always_comb begin
      case (mode_ff)
         MODE_LBRACE: begin
            partner = CH_LBRACE; kind_dbl = KIND_LBRACE2; kind_single = KIND_LBRACE;
         end
         MODE_RBRACE: begin
            partner = CH_RBRACE; kind_dbl = KIND_RBRACE2; kind_single = KIND_RBRACE;
         end
         default: begin
            partner = CH_GT; kind_dbl = KIND_ARROW; kind_single = KIND_MINUS;
         end
      endcase
   end

   // byte stage, then end-of-source stage
   always_comb begin
      mode_mid  = mode_ff;
      qs_mid    = qs_ff;
      begin_mid = begin_ff;
      pos_mid   = pos_ff;
      line_mid  = line_ff;
      cand_mid  = cand_ff;
      wlen_mid  = wlen_ff;
      fall      = 1'b0;
      a_long    = 1'b0;
      tok_v     = '0;
      for (int i = 0; i < 4; i++) begin
         tok_c[i] = '0;
      end

      if (item_valid && byte_present) begin
         pos_mid = after;
         case (mode_ff)
            MODE_LBRACE, MODE_RBRACE, MODE_MINUS: begin
               tok_v[0] = 1'b1;
               mode_mid = MODE_IDLE;
               if (data_byte == partner) begin
                  tok_c[0].kind = kind_dbl;
                  a_long = 1'b1;
               end else begin
                  tok_c[0].kind = kind_single;
                  fall = 1'b1;
               end
            end
            MODE_STRING: begin
               if (data_byte == (qs_ff ? CH_SQUOTE : CH_DQUOTE)) begin
                  tok_v[0] = 1'b1;
                  tok_c[0].kind = KIND_STRING;
                  a_long = 1'b1;
                  mode_mid = MODE_IDLE;
               end else if (data_byte == CH_LF) begin
                  line_mid = line_up(line_ff);
               end
            end
            MODE_IDENT: begin
               if (is_word_char(data_byte)) begin
                  cand_mid = kw_step(cand_ff, wlen_ff, data_byte);
                  wlen_mid = wlen_up(wlen_ff);
               end else begin
                  tok_v[0] = 1'b1;
                  tok_c[0].kind = kw_kind(cand_ff, wlen_ff);
                  mode_mid = MODE_IDLE;
                  fall = 1'b1;
               end
            end
            default: fall = 1'b1;
         endcase

         if (fall) begin
            begin_mid = here;
            if (data_byte == CH_COLON) begin
               tok_v[1] = 1'b1;
               tok_c[1].kind = KIND_COLON;
            end else if (data_byte == CH_LBRACE) begin
               mode_mid = MODE_LBRACE;
            end else if (data_byte == CH_RBRACE) begin
               mode_mid = MODE_RBRACE;
            end else if (data_byte == CH_MINUS) begin
               mode_mid = MODE_MINUS;
            end else if (data_byte == CH_DQUOTE || data_byte == CH_SQUOTE) begin
               mode_mid = MODE_STRING;
               qs_mid = (data_byte == CH_SQUOTE);
            end else if (data_byte inside {CH_SPACE, CH_CR, CH_TAB}) begin
               mode_mid = MODE_IDLE;
            end else if (data_byte == CH_LF) begin
               line_mid = line_up(line_ff);
            end else if (is_alpha(data_byte) || data_byte == CH_UNDER) begin
               mode_mid = MODE_IDENT;
               cand_mid = kw_step(4'hF, 4'd0, data_byte);
               wlen_mid = 4'd1;
            end else begin
               tok_v[1] = 1'b1;
               tok_c[1].kind = KIND_UNKNOWN;
            end
         end
      end

      tok_c[0].offset = sat_off(begin_ff);
      tok_c[0].length = sat_len((a_long ? after : here) - begin_ff);
      tok_c[0].line   = line_ff;
      tok_c[1].offset = sat_off(here);
      tok_c[1].length = sat_len(after - here);
      tok_c[1].line   = line_ff;

      // pending brace, minus or word left after the byte is flushed at end of source; an open string is dropped
      if (item_valid && end_of_source) begin
         tok_v[3] = 1'b1;
         case (mode_mid)
            MODE_LBRACE: begin tok_v[2] = 1'b1; tok_c[2].kind = KIND_LBRACE; end
            MODE_RBRACE: begin tok_v[2] = 1'b1; tok_c[2].kind = KIND_RBRACE; end
            MODE_MINUS:  begin tok_v[2] = 1'b1; tok_c[2].kind = KIND_MINUS;  end
            MODE_IDENT: begin
               tok_v[2] = 1'b1;
               tok_c[2].kind = kw_kind(cand_mid, wlen_mid);
            end
            default: tok_v[2] = 1'b0;
         endcase
      end
      tok_c[2].offset = sat_off(begin_mid);
      tok_c[2].length = sat_len(pos_mid - begin_mid);
      tok_c[2].line   = line_mid;
      tok_c[3].kind   = KIND_END;
      tok_c[3].offset = sat_off(pos_mid);
      tok_c[3].length = '0;
      tok_c[3].line   = line_mid;
      tok_c[3].last   = 1'b1;
   end

   // pack valid tokens into consecutive slots
   always_comb begin
      entry = '0;
      slot  = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (tok_v[i] && slot != 2'd3) begin
            entry.tok[slot] = tok_c[i];
            slot = slot + 2'd1;
         end
      end
      entry.count = slot;
   end

   assign push = |tok_v;

   always_comb begin
      mode_in       = mode_mid;
      qs_in         = qs_mid;
      begin_in      = begin_mid;
      pos_in        = pos_mid;
      line_in       = line_mid;
      cand_in       = cand_mid;
      wlen_in       = wlen_mid;
      start_line_in = start_line_ff;
      if (item_valid && end_of_source) begin
         mode_in  = MODE_IDLE;
         qs_in    = 1'b0;
         begin_in = '0;
         pos_in   = '0;
         line_in  = start_line_ff;
         cand_in  = '0;
         wlen_in  = '0;
      end
      if (csr_write) begin
         start_line_in = csr_data;
         if (pos_in == '0) begin
            line_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         qs_ff         <= 1'b0;
         begin_ff      <= '0;
         pos_ff        <= '0;
         line_ff       <= START_LINE_RESET;
         cand_ff       <= '0;
         wlen_ff       <= '0;
         start_line_ff <= START_LINE_RESET;
      end else begin
         mode_ff       <= mode_in;
         qs_ff         <= qs_in;
         begin_ff      <= begin_in;
         pos_ff        <= pos_in;
         line_ff       <= line_in;
         cand_ff       <= cand_in;
         wlen_ff       <= wlen_in;
         start_line_ff <= start_line_in;
      end
   end

endmodule

`default_nettype wire

@@ src/script_token_lexer_top.sv @@
// Script token lexer: one byte per cycle in, one token per cycle out, when not stalled.
// A transaction's first token is queued at the accepting edge, then registered onto rsp.
// Throughput: one byte per cycle; a byte yields up to three tokens, drained one per cycle
// while rsp is ready from a four-entry queue, so req stalls only while that queue is full.
// Reset (synchronous): scanner idle, offset 0, line and start_line 1, queue empty.
// Depends on stl_pkg and stl_scan.
`default_nettype none

module script_token_lexer_top #(
   parameter longint unsigned MAX_SOURCE_BYTES = stl_pkg::MAX_SOURCE_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tuser,   // byte_present
   input  wire logic        req_tlast,   // end_of_source
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // token_offset[19:0], token_length[40:20],
                                         // token_line[56:41], zero fill
   output logic [3:0]       rsp_tuser,   // token_kind
   output logic             rsp_tlast,   // last_token
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data    // start_line
);
   import stl_pkg::*;

   logic              accept, push, load, pop;
   entry_type         entry;

   entry_type         q_data_ff [QUEUE_DEPTH];
   logic [1:0]        q_cnt_ff  [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] q_count_ff, q_count_in;
   logic [1:0]        sub_ff, sub_in, head_cnt;
   logic              rsp_valid_ff, rsp_valid_in;
   token_type         rsp_tok_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = (q_count_ff != QCNT_W'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   stl_scan #(
      .MAX_SOURCE_BYTES (MAX_SOURCE_BYTES)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (accept),
      .data_byte     (req_tdata),
      .byte_present  (req_tuser),
      .end_of_source (req_tlast),
      .csr_write     (csr_valid),
      .csr_data      (csr_data),
      .push          (push),
      .entry         (entry)
   );

   assign head_cnt = q_cnt_ff[rd_ptr_ff];
   assign load     = (q_count_ff != '0) && (!rsp_valid_ff || rsp_tready);
   assign pop      = load && (sub_ff == head_cnt - 2'd1);

   always_comb begin
      wr_ptr_in    = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      q_count_in   = q_count_ff + QCNT_W'(push) - QCNT_W'(pop);
      sub_in       = pop ? 2'd0 : (load ? sub_ff + 2'd1 : sub_ff);
      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         q_count_ff   <= '0;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         q_count_ff   <= q_count_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // queue storage and output register
   always_ff @(posedge clock) begin
      if (push) begin
         q_data_ff[wr_ptr_ff] <= entry;
         q_cnt_ff[wr_ptr_ff]  <= entry.count;
      end
      if (load) begin
         rsp_tok_ff <= q_data_ff[rd_ptr_ff].tok[sub_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_tok_ff.line, rsp_tok_ff.length, rsp_tok_ff.offset};
   assign rsp_tuser  = rsp_tok_ff.kind;
   assign rsp_tlast  = rsp_tok_ff.last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> q_count_ff != QCNT_W'(QUEUE_DEPTH))
      else $error("push into full result queue");

   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser == KIND_END)
      else $error("last flag on a token that is not the end token");

endmodule

`default_nettype wire

@@ sim/stl_token_checker.sv @@
// Scoreboard for the script token lexer: watches the req, rsp and csr channels,
// predicts the tokens of every accepted byte transaction and compares them in order.
// Depends on stl_pkg for the token record, token kinds and character codes.
module stl_token_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tuser,   // byte_present
   input  wire logic        req_tlast,   // end_of_source
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,   // token_offset, token_length, token_line, zero fill
   input  wire logic [3:0]  rsp_tuser,   // token_kind
   input  wire logic        rsp_tlast,   // last_token
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [15:0] csr_data,    // start_line
   output int               fail_count,
   output int               tokens_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import stl_pkg::*;

   localparam int REPORT_CAP = 200;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_LBRACE, SCAN_RBRACE, SCAN_MINUS, SCAN_STRING, SCAN_WORD
   } scan_mode_type;

   // predicted lexer state
   logic [15:0]     first_line;
   scan_mode_type   mode;
   logic            quote_single;
   longint unsigned begin_pos;
   longint unsigned byte_pos;
   logic [15:0]     line_no;
   logic [3:0]      kw_live;
   logic [3:0]      word_len;

   token_type       tokens_due[$];
   token_type       want;
   int              errors = 0;

   function automatic logic [3:0] kw_size(input int k);
      case (k)
         0:       return 4'd6;
         1:       return 4'd7;
         2:       return 4'd8;
         default: return 4'd3;
      endcase
   endfunction

   function automatic logic [7:0] keyword_char(input int k, input logic [3:0] pos);
      logic [63:0] txt;
      case (k)
         0:       txt = {"Listen", 16'h0};
         1:       txt = {"Animate", 8'h0};
         2:       txt = "Delegate";
         default: txt = {"Vir", 40'h0};
      endcase
      return txt[8*(7 - int'(pos[2:0])) +: 8];
   endfunction

   function automatic logic word_start(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == CH_UNDER;
   endfunction

   function automatic logic word_more(input logic [7:0] b);
      return word_start(b) || (b >= "0" && b <= "9");
   endfunction

   function automatic void bump_line();
      if (line_no != LINE_MAX) line_no = line_no + 16'd1;
   endfunction

   function automatic void post_token(input logic [3:0] kind, input longint unsigned off,
                                      input longint unsigned len, input logic last);
      token_type t;
      t.kind   = kind;
      t.offset = (off > OFF_MAX) ? OFF_MAX : off[OFF_W-1:0];
      t.length = (len > LEN_MAX) ? LEN_MAX : len[LEN_W-1:0];
      t.line   = line_no;
      t.last   = last;
      tokens_due = {tokens_due, t};
   endfunction

   // narrow the keyword candidates with the next byte of the word
   function automatic void word_push(input logic [7:0] b);
      for (int k = 0; k < 4; k++) begin
         if (word_len >= kw_size(k) || keyword_char(k, word_len) != b) kw_live[k] = 1'b0;
      end
      if (word_len != 4'hF) word_len = word_len + 4'd1;
   endfunction

   function automatic logic [3:0] word_kind();
      logic [3:0] kind;
      kind = KIND_IDENT;
      for (int k = 3; k >= 0; k--) begin
         if (kw_live[k] && word_len == kw_size(k)) kind = KIND_KEYWORD + 4'(k);
      end
      return kind;
   endfunction

   function automatic void close_pending(input longint unsigned cur);
      longint unsigned len;
      len = cur - begin_pos;
      case (mode)
         SCAN_LBRACE: post_token(KIND_LBRACE, begin_pos, len, 1'b0);
         SCAN_RBRACE: post_token(KIND_RBRACE, begin_pos, len, 1'b0);
         SCAN_MINUS:  post_token(KIND_MINUS, begin_pos, len, 1'b0);
         SCAN_WORD:   post_token(word_kind(), begin_pos, len, 1'b0);
         default: ;
      endcase
      mode = SCAN_IDLE;
   endfunction

   function automatic void restart_source();
      mode         = SCAN_IDLE;
      quote_single = 1'b0;
      begin_pos    = 0;
      byte_pos     = 0;
      line_no      = first_line;
      kw_live      = 4'h0;
      word_len     = 4'h0;
   endfunction

   function automatic void scan_byte(input logic [7:0] b);
      longint unsigned here, after;
      logic [7:0]      partner;
      logic [3:0]      pair_kind;
      here     = byte_pos;
      after    = (here < MAX_SOURCE_BYTES_DEF) ? here + 1 : here;
      byte_pos = after;
      case (mode)
         SCAN_LBRACE, SCAN_RBRACE, SCAN_MINUS: begin
            partner   = (mode == SCAN_LBRACE) ? CH_LBRACE :
                        (mode == SCAN_RBRACE) ? CH_RBRACE : CH_GT;
            pair_kind = (mode == SCAN_LBRACE) ? KIND_LBRACE2 :
                        (mode == SCAN_RBRACE) ? KIND_RBRACE2 : KIND_ARROW;
            if (b == partner) begin
               post_token(pair_kind, begin_pos, after - begin_pos, 1'b0);
               mode = SCAN_IDLE;
               return;
            end
            close_pending(here);
         end
         SCAN_STRING: begin
            if (b == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
               post_token(KIND_STRING, begin_pos, after - begin_pos, 1'b0);
               mode = SCAN_IDLE;
            end else if (b == CH_LF) begin
               bump_line();
            end
            return;
         end
         SCAN_WORD: begin
            if (word_more(b)) begin
               word_push(b);
               return;
            end
            close_pending(here);
         end
         default: ;
      endcase

      begin_pos = here;
      if (b == CH_COLON) begin
         post_token(KIND_COLON, here, after - here, 1'b0);
      end else if (b == CH_LBRACE) begin
         mode = SCAN_LBRACE;
      end else if (b == CH_RBRACE) begin
         mode = SCAN_RBRACE;
      end else if (b == CH_MINUS) begin
         mode = SCAN_MINUS;
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
         mode         = SCAN_STRING;
         quote_single = (b == CH_SQUOTE);
      end else if (b == CH_SPACE || b == CH_CR || b == CH_TAB) begin
         // whitespace, nothing to do
      end else if (b == CH_LF) begin
         bump_line();
      end else if (word_start(b)) begin
         mode     = SCAN_WORD;
         kw_live  = 4'hF;
         word_len = 4'h0;
         word_push(b);
      end else begin
         post_token(KIND_UNKNOWN, here, after - here, 1'b0);
      end
   endfunction

   function automatic void end_source();
      // an open string is dropped without a token
      if (mode == SCAN_STRING) mode = SCAN_IDLE;
      else close_pending(byte_pos);
      post_token(KIND_END, byte_pos, 0, 1'b1);
      restart_source();
   endfunction

   function automatic void check_field(input string name, input longint unsigned exp_val,
                                       input longint unsigned act_val);
      if (exp_val != act_val) begin
         if (errors < REPORT_CAP) begin
            $display("%0t: token %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
         end
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         first_line = START_LINE_RESET;
         restart_source();
         tokens_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            first_line = csr_data;
            // takes effect at once only before the first byte of a source
            if (byte_pos == 0) line_no = first_line;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) scan_byte(req_tdata);
            if (req_tlast) end_source();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (tokens_due.size() == 0) begin
               if (errors < REPORT_CAP) begin
                  $display("%0t: unexpected token, expected none, actual kind %0d offset %0d",
                           $time, rsp_tuser, rsp_tdata[19:0]);
               end
               errors++;
            end else begin
               want = tokens_due.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("offset", want.offset, rsp_tdata[19:0]);
               check_field("length", want.length, rsp_tdata[40:20]);
               check_field("line", want.line, rsp_tdata[56:41]);
               check_field("last", want.last, rsp_tlast);
            end
         end
      end
      tokens_pending <= tokens_due.size();
      fail_count     <= errors;
   end

endmodule

@@ sim/tb.sv @@
// Testbench top for script_token_lexer_top: clock, reset, byte stimulus, csr writes,
// receiver back-pressure and the verdict. Depends on stl_pkg, the RTL and stl_token_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stl_pkg::*;

   localparam int SETTLE     = 4;
   localparam int HOLD_LEN   = 80;
   localparam int QUIET_MAX  = 1000;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = 16'h0000;

   int          fail_count;
   int          tokens_pending;

   int          send_gap    = 37;
   int          take_gap    = 80;
   int          hold_asked  = 0;
   int          hold_served = 0;
   int          hold_left   = 0;
   int          quiet_cycles = 0;
   int          items_sent  = 0;
   logic [7:0]  src_q[$];

   script_token_lexer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   stl_token_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .tokens_pending (tokens_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off whenever one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_LEN;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= take_gap);
         end
      end
   end

   // watchdog: too long without any transaction on any channel
   initial begin
      while (quiet_cycles < QUIET_MAX) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic [7:0] b, input logic present, input logic eos);
      while ($urandom_range(99) < send_gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= present;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (present || eos) items_sent++;
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (tokens_pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_start_line(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_byte(input logic [7:0] c);
      src_q = {src_q, c};
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] word_char(input bit lead);
      int r;
      r = lead ? $urandom_range(4) : $urandom_range(6);
      case (r)
         0, 1:    return 8'($urandom_range("A", "Z"));
         2, 3:    return 8'($urandom_range("a", "z"));
         4:       return CH_UNDER;
         default: return 8'($urandom_range("0", "9"));
      endcase
   endfunction

   function automatic void add_ident();
      int n;
      n = $urandom_range(1, ($urandom_range(3) == 0) ? 20 : 6);
      add_byte(word_char(1'b1));
      for (int i = 1; i < n; i++) add_byte(word_char(1'b0));
   endfunction

   function automatic void add_keywordish();
      case ($urandom_range(11))
         0:  add_text("Listen");
         1:  add_text("Animate");
         2:  add_text("Delegate");
         3:  add_text("Vir");
         4:  add_text("Vi");
         5:  add_text("Virtual");
         6:  add_text("Listener");
         7:  add_text("Animat");
         8:  add_text("Delegates");
         9:  add_text("listen");
         10: add_text("Vir_2");
         default: add_text("Delegate9");
      endcase
   endfunction

   function automatic void add_punct();
      case ($urandom_range(9))
         0: add_text(":");
         1: add_text("{");
         2: add_text("{{");
         3: add_text("}");
         4: add_text("}}");
         5: add_text("->");
         6: add_text("-");
         7: add_text("{{{");
         8: add_text("-->");
         default: add_text("}:");
      endcase
   endfunction

   // quoted text; may hold line feeds, the other quote and any byte but its own quote
   function automatic void add_quoted(input bit closed);
      logic [7:0] q, c;
      int         n;
      q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
      n = $urandom_range(0, 8);
      add_byte(q);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: c = CH_LF;
            1: c = (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
            2: do c = 8'($urandom_range(255)); while (c == q);
            default: do c = 8'($urandom_range(32, 126)); while (c == q);
         endcase
         add_byte(c);
      end
      if (closed) add_byte(q);
   endfunction

   function automatic void add_blank();
      case ($urandom_range(3))
         0: add_byte(CH_SPACE);
         1: add_byte(CH_TAB);
         2: add_byte(CH_CR);
         default: add_byte(CH_LF);
      endcase
   endfunction

   function automatic void build_source();
      int n, r;
      src_q.delete();
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 25)      add_keywordish();
         else if (r < 40) add_ident();
         else if (r < 55) add_punct();
         else if (r < 65) add_quoted(1'b1);
         else if (r < 85) add_blank();
         else if (r < 92) add_byte(8'($urandom_range("0", "9")));
         else             add_byte(8'($urandom_range(255)));
         if ($urandom_range(1)) add_blank();
      end
      if ($urandom_range(19) == 0) add_quoted(1'b0);
   endfunction

   // drives src_q as one source; with split, start_line is rewritten halfway through
   task automatic send_source(input bit split, input logic [15:0] value);
      bit sep_end;
      int cut;
      sep_end = ($urandom_range(3) == 0) || (src_q.size() == 0);
      cut     = src_q.size() / 2;
      for (int i = 0; i < src_q.size(); i++) begin
         if (split && i == cut && cut > 0) begin
            wait_drain();
            write_start_line(value);
         end
         if ($urandom_range(49) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         send_item(src_q[i], 1'b1, !sep_end && (i == src_q.size() - 1));
      end
      if (sep_end) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   task automatic run_phase(input int s_gap, input int t_gap, input logic [15:0] first,
                            input int count);
      int  goal;
      bit  split_done, split;
      send_gap = s_gap;
      take_gap = t_gap;
      wait_drain();
      write_start_line(first);
      goal       = items_sent + count;
      split_done = 1'b0;
      while (items_sent < goal) begin
         build_source();
         split = !split_done && src_q.size() >= 2 && $urandom_range(3) == 0;
         if (split) split_done = 1'b1;
         send_source(split, 16'($urandom_range(65535)));
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all punctuation kinds, a keyword, bytes at and above 128, a string across a line feed
      src_q.delete();
      add_text("{{}}->{}-:'\n'Vir");
      add_byte(8'hFF);
      add_byte(8'h80);
      add_byte(8'h00);
      send_source(1'b0, 16'h0000);
      send_item(8'h5A, 1'b0, 1'b0);      // carries nothing
      send_item(8'hA5, 1'b0, 1'b1);      // empty source
      src_q.delete();
      add_text("\"a");                   // open string at end of source
      send_source(1'b0, 16'h0000);

      run_phase(37, 80, 16'h0000, 130);
      run_phase(80, 37, 16'hFFFF, 130);

      // receiver holds off while a token-heavy burst keeps coming
      send_gap = 0;
      take_gap = 0;
      wait_drain();
      hold_asked++;
      src_q.delete();
      add_text("::{:-:}:Vir:::{{::-:::");
      send_source(1'b0, 16'h0000);
      wait_drain();

      run_phase(0, 0, 16'($urandom_range(65535)), 130);

      wait_drain();
      repeat (8) @(negedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
